@@ rtl/core/cse_pkg.sv @@
// Package for the capped record store: sizes, entry and result types,
// controller states and the intensity clamp. No dependencies.
package cse_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 6;
  localparam int CMP_W    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);
  localparam logic [12:0]      INT_ONE   = 13'd4096;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [15:0]        type_id;
    logic [15:0]        context_id;
    logic [31:0]        time_stamp;
    logic signed [15:0] intensity;
    logic [31:0]        loc_x;
    logic [31:0]        loc_y;
    logic [31:0]        loc_z;
  } cse_in_t;

  typedef struct packed {
    logic [15:0] entry_type;
    logic [15:0] entry_context;
    logic [31:0] entry_time;
    logic [12:0] entry_intensity;
    logic [31:0] entry_loc_x;
    logic [31:0] entry_loc_y;
    logic [31:0] entry_loc_z;
    logic [5:0]  stored_count;
    logic        evicted_flag;
    logic        ignored_flag;
    logic        last_flag;
  } cse_res_t;

  typedef struct packed {
    logic [15:0] type_id;
    logic [15:0] context_id;
    logic [31:0] time_stamp;
    logic [12:0] intensity;
    logic [31:0] loc_x;
    logic [31:0] loc_y;
    logic [31:0] loc_z;
  } cse_entry_t;

  typedef struct packed {
    logic take_next;
    logic take_new;
  } cse_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP,
    ST_SCAN,
    ST_CLOSE
  } cse_state_e;

  function automatic logic [12:0] cse_clamp(input logic signed [15:0] v);
    logic [12:0] r;
    if (v[15]) begin
      r = 13'd0;
    end else if (v[14:0] > 15'(INT_ONE)) begin
      r = INT_ONE;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/capped_store_evict_lowest.sv @@
// Top level of the capped record store: a rotating chain of entry cells
// driven by the sequencer. Depends on cse_pkg, cse_cell and cse_ctrl.
//
//   channel   | ports                       | transfer
//   ----------+-----------------------------+------------------------------
//   command   | start, busy, item_i         | start high while busy low
//   result    | res_valid_o, res_o          | every cycle res_valid_o is high
//   config    | cfg_we_i, cfg_data_i        | every cycle cfg_we_i is high
//
// Record without eviction, or ignored: result in the cycle after the accept.
// Record that evicts: the accept state, a full rotation of the chain past
// the head cell to find the first lowest intensity, and a close-up state.
// Dump: the accept state, then one full rotation of the chain; one entry
// leaves per cycle until every stored entry is out.
// Reset clears the entry count and sets the cap to 32; cells are not cleared.
// The receiver cannot stall: each result shows for exactly one cycle.
module capped_store_evict_lowest import cse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cse_in_t          item_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             res_valid_o,
  output cse_res_t         res_o
);

  cse_entry_t                    cell_q   [CAPACITY];
  cse_cell_ctrl_t [CAPACITY-1:0] cell_ctrl;
  cse_entry_t                    new_entry;

  cse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (cell_q[0]),
    .new_entry_o (new_entry),
    .cell_ctrl_o (cell_ctrl),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // the last cell wraps to the head so a full rotation restores order
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cse_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[g]),
      .next_i (cell_q[(g + 1) % CAPACITY]),
      .new_i  (new_entry),
      .q_o    (cell_q[g])
    );
  end

endmodule

@@ rtl/core/cse_cell.sv @@
// One storage cell of the record chain: holds one entry and loads either
// its right neighbor or the new entry. Depends on cse_pkg.
module cse_cell import cse_pkg::*; (
  input  logic           clk_i,
  input  cse_cell_ctrl_t ctrl_i,
  input  cse_entry_t     next_i,
  input  cse_entry_t     new_i,
  output cse_entry_t     q_o
);

  cse_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_new) begin
      entry_q <= new_i;
    end else if (ctrl_i.take_next) begin
      entry_q <= next_i;
    end
  end

  assign q_o = entry_q;

endmodule

@@ rtl/core/cse_ctrl.sv @@
// Sequencer for the record chain: cap register, entry count, lowest-intensity
// scan, close-up and write decode, result register. Depends on cse_pkg.
module cse_ctrl import cse_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  cse_in_t                       item_i,
  input  logic                          cfg_we_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  cse_entry_t                    head_i,
  output cse_entry_t                    new_entry_o,
  output cse_cell_ctrl_t [CAPACITY-1:0] cell_ctrl_o,
  output logic                          res_valid_o,
  output cse_res_t                      res_o
);

  cse_state_e state_q, state_d;

  logic [CFG_W-1:0] cap_q;
  logic [CNT_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] low_q;
  logic [12:0]      min_q;
  cse_entry_t       nr_q;
  cse_res_t         res_q, res_d;
  logic             res_vld_q, res_load;

  cse_entry_t       in_entry;
  logic [CMP_W-1:0] cap_ext, cap_eff;
  logic             need_evict, accept, rec_ok;
  logic             scan_live, scan_end, new_lower;
  logic             close_en, write_en;
  logic [CNT_W-1:0] write_idx;

  always_comb begin
    in_entry.type_id    = item_i.type_id;
    in_entry.context_id = item_i.context_id;
    in_entry.time_stamp = item_i.time_stamp;
    in_entry.intensity  = cse_clamp(item_i.intensity);
    in_entry.loc_x      = item_i.loc_x;
    in_entry.loc_y      = item_i.loc_y;
    in_entry.loc_z      = item_i.loc_z;
  end

  // saturate the cap to 1..CAPACITY
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign accept     = start && (state_q == ST_IDLE);
  assign rec_ok     = (item_i.cmd == CMD_RECORD) && (item_i.type_id != '0);
  assign need_evict = CMP_W'(n_q) >= cap_eff;
  assign scan_live  = CNT_W'(k_q) < n_q;
  assign scan_end   = k_q == IDX_W'(CAPACITY - 1);
  assign new_lower  = nr_q.intensity < min_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.cmd == CMD_DUMP) begin
            if (n_q != '0) begin
              state_d = ST_DUMP;
            end
          end else if (rec_ok && need_evict) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_DUMP: begin
        if (scan_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs: chain controls and result
  always_comb begin
    busy        = 1'b0;
    close_en    = 1'b0;
    write_en    = 1'b0;
    write_idx   = n_q;
    new_entry_o = nr_q;
    res_load    = 1'b0;
    res_d       = '0;
    n_d         = n_q;
    res_d.stored_count = 6'(n_q);
    res_d.last_flag    = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl_o[i] = '0;
    end
    case (state_q)
      ST_IDLE: begin
        new_entry_o = in_entry;
        if (accept) begin
          res_load = 1'b1;
          if (item_i.cmd == CMD_DUMP) begin
            // empty dump gives one zero result; otherwise the dump state reports
            res_load = (n_q == '0);
          end else if (!rec_ok) begin
            res_d.ignored_flag = 1'b1;
          end else if (!need_evict) begin
            write_en  = 1'b1;
            write_idx = n_q;
            n_d       = n_q + CNT_W'(1);
            res_d.stored_count = 6'(n_d);
          end else begin
            res_load = 1'b0;
          end
        end
      end
      ST_DUMP: begin
        busy = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
          cell_ctrl_o[i].take_next = 1'b1;
        end
        if (scan_live) begin
          res_load              = 1'b1;
          res_d.entry_type      = head_i.type_id;
          res_d.entry_context   = head_i.context_id;
          res_d.entry_time      = head_i.time_stamp;
          res_d.entry_intensity = head_i.intensity;
          res_d.entry_loc_x     = head_i.loc_x;
          res_d.entry_loc_y     = head_i.loc_y;
          res_d.entry_loc_z     = head_i.loc_z;
          res_d.last_flag       = (CNT_W'(k_q) + CNT_W'(1)) == n_q;
        end
      end
      ST_SCAN: begin
        busy = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
          cell_ctrl_o[i].take_next = 1'b1;
        end
      end
      ST_CLOSE: begin
        busy               = 1'b1;
        res_load           = 1'b1;
        res_d.evicted_flag = 1'b1;
        // unless new is strictly lower: drop lowest, close up, append new at end
        if (!new_lower) begin
          close_en  = 1'b1;
          write_en  = 1'b1;
          write_idx = n_q - CNT_W'(1);
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    if (close_en || write_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_ctrl_o[i].take_next = close_en && (CNT_W'(i) >= CNT_W'(low_q)) &&
                                   (CNT_W'(i) + CNT_W'(1) < n_q);
        cell_ctrl_o[i].take_new  = write_en && (CNT_W'(i) == write_idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= CFG_RESET;
      n_q       <= '0;
      k_q       <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      res_vld_q <= res_load;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (state_q == ST_DUMP || state_q == ST_SCAN) begin
        k_q <= k_q + IDX_W'(1);
      end else begin
        k_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
    if (accept) begin
      nr_q <= in_entry;
    end
    // first entry seeds the minimum, later ones replace it only when strictly lower
    if (state_q == ST_SCAN && scan_live &&
        (k_q == '0 || head_i.intensity < min_q)) begin
      min_q <= head_i.intensity;
      low_q <= k_q;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule
